// ===== rtl/hss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, register indexes and helpers for the substring search block.
// ----------------------------------------------------------------------------
package hss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_BYTES  = 32;
    localparam int PAT_W      = PAT_BYTES * 8;
    localparam int LEN_W      = 6;
    localparam int OFF_W      = 12;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD     = 3'd5;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
        logic             case_fold;
    } cfg_t;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] match_offset;
        logic [LEN_W-1:0] match_length;
    } result_t;

    // ASCII upper-casing of a..z when case is ignored.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && (c >= 8'h61) && (c <= 8'h7A)) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hss_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_cfg
// Configuration register file: pattern bytes, pattern length and case mode.
// ----------------------------------------------------------------------------
module hss_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] wr_data,
    output hss_pkg::cfg_t                  cfg
);

    logic [hss_pkg::CFG_DATA_W-1:0] pat0_reg;
    logic [hss_pkg::CFG_DATA_W-1:0] pat1_reg;
    logic [hss_pkg::CFG_DATA_W-1:0] pat2_reg;
    logic [hss_pkg::CFG_DATA_W-1:0] pat3_reg;
    logic [hss_pkg::LEN_W-1:0]      len_reg;
    logic                           icase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat0_reg  <= '0;
            pat1_reg  <= '0;
            pat2_reg  <= '0;
            pat3_reg  <= '0;
            len_reg   <= hss_pkg::LEN_W'(1);
            icase_reg <= 1'b0;
        end else if (wr_en) begin
            case (wr_index)
                hss_pkg::REG_PATTERN_0_7:   pat0_reg  <= wr_data;
                hss_pkg::REG_PATTERN_8_15:  pat1_reg  <= wr_data;
                hss_pkg::REG_PATTERN_16_23: pat2_reg  <= wr_data;
                hss_pkg::REG_PATTERN_24_31: pat3_reg  <= wr_data;
                hss_pkg::REG_PATTERN_LEN:   len_reg   <= wr_data[hss_pkg::LEN_W-1:0];
                hss_pkg::REG_CASE_FOLD:     icase_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern   = {pat3_reg, pat2_reg, pat1_reg, pat0_reg};
    assign cfg.length    = len_reg;
    assign cfg.case_fold = icase_reg;

endmodule

// ===== rtl/hss_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_core
// Text window, parallel pattern compare and per-line match state.
// ----------------------------------------------------------------------------
module hss_core #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX    = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       text_byte,
    input  logic             last_byte,
    input  hss_pkg::cfg_t    cfg,
    output hss_pkg::result_t result
);

    localparam int POS_CAP = LINE_MAX + PATTERN_MAX - 1;
    localparam int POS_W   = $clog2(POS_CAP + 1);
    localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W   = hss_pkg::LEN_W;
    localparam int OFF_W   = hss_pkg::OFF_W;

    logic [7:0]       window_reg [PATTERN_MAX];
    logic [7:0]       window_next[PATTERN_MAX];
    logic [POS_W-1:0] pos_reg;
    logic             seen_reg;
    logic [OFF_W-1:0] start_reg;

    logic [LEN_W-1:0]       eff_len;
    logic [PATTERN_MAX-1:0] eq_vec;
    logic [POS_W:0]         pos_inc;
    logic [POS_W:0]         start;
    logic                   hit;

    // Newest byte at the front of the window.
    always_comb begin
        window_next[0] = text_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            window_next[j] = window_reg[j-1];
        end
    end

    always_comb begin
        if (cfg.length > LEN_W'(PATTERN_MAX)) begin
            eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            eff_len = cfg.length;
        end
    end

    // Pattern byte i lines up with window entry eff_len-1-i.
    always_comb begin
        logic [LEN_W-1:0] d;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            d = eff_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) >= eff_len) begin
                eq_vec[i] = 1'b1;
            end else begin
                eq_vec[i] =
                    hss_pkg::fold_byte(window_next[d[IDX_W-1:0]], cfg.case_fold) ==
                    hss_pkg::fold_byte(cfg.pattern[i*8 +: 8], cfg.case_fold);
            end
        end
    end

    assign pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign start   = pos_inc - (POS_W+1)'(eff_len);
    assign hit     = !seen_reg && (eff_len != '0) &&
                     (pos_inc >= (POS_W+1)'(eff_len)) &&
                     (start < (POS_W+1)'(LINE_MAX)) && (&eq_vec);

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                window_reg[j] <= window_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end else if (accept) begin
            if (last_byte) begin
                pos_reg   <= '0;
                seen_reg  <= 1'b0;
                start_reg <= '0;
            end else begin
                if (pos_reg < POS_W'(POS_CAP)) begin
                    pos_reg <= pos_inc[POS_W-1:0];
                end
                if (hit) begin
                    seen_reg  <= 1'b1;
                    start_reg <= OFF_W'(start);
                end
            end
        end
    end

    always_comb begin
        result.found = seen_reg || hit;
        if (seen_reg) begin
            result.match_offset = start_reg;
        end else if (hit) begin
            result.match_offset = OFF_W'(start);
        end else begin
            result.match_offset = '0;
        end
        result.match_length = result.found ? eff_len : '0;
    end

endmodule

// ===== rtl/horspool_substring_search.sv =====
`timescale 1ns / 1ps
// Result: a result word appears on m_* in the cycle after the marked last byte is taken.
// Throughput: one text byte per cycle; the window compare finishes within that cycle.
// Input stalls only while a result word is held and m_ready is low.
// Reset: synchronous, active low; pattern clears to zero, length to one, case
// sensitivity on, and the line state (position, match flag, start) clears.
// ----------------------------------------------------------------------------
// horspool_substring_search
// Streaming leftmost substring search over a line, one byte per word.
// ----------------------------------------------------------------------------
module horspool_substring_search #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX    = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,

    // Text input, one byte per word.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_text_byte,
    input  logic                           s_last_byte,

    // One result word per line.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [hss_pkg::OFF_W-1:0]      m_match_offset,
    output logic [hss_pkg::LEN_W-1:0]      m_match_length
);

    hss_pkg::cfg_t    cfg;
    hss_pkg::result_t core_result;
    hss_pkg::result_t result_reg;
    hss_pkg::result_t result_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             in_accept;

    // Registers are always writable; software must only write between lines, which the block does not enforce.
    assign cfg_ready = 1'b1;

    hss_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A word is taken whenever the output register is empty or being drained,
    // so a stream of bytes runs at full rate as long as the sink keeps up.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    hss_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .LINE_MAX    (LINE_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (in_accept),
        .text_byte (s_text_byte),
        .last_byte (s_last_byte),
        .cfg       (cfg),
        .result    (core_result)
    );

    // The result register is loaded only by the last byte of a line; any
    // other byte leaves a pending result untouched.
    always_comb begin
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (in_accept && s_last_byte) begin
            m_valid_next = 1'b1;
            result_next  = core_result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = result_reg.found;
    assign m_match_offset = result_reg.match_offset;
    assign m_match_length = result_reg.match_length;

endmodule
